// ===== design/txrq_pkg.sv =====
package txrq_pkg;

    // Character codes
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    // Result field widths
    localparam int unsigned FILL_W = 11;

    // Overflow notice: LF CR LF CR "***Buffer Full***" LF CR LF CR
    localparam int unsigned NOTICE_LEN   = 25;
    localparam int unsigned NOTICE_IDX_W = 5;
    localparam logic [NOTICE_IDX_W-1:0] NOTICE_LAST = NOTICE_IDX_W'(NOTICE_LEN - 1);

    localparam logic [7:0] NOTICE_ROM [NOTICE_LEN] = '{
        8'h0A, 8'h0D, 8'h0A, 8'h0D,
        8'h2A, 8'h2A, 8'h2A,
        8'h42, 8'h75, 8'h66, 8'h66, 8'h65, 8'h72, 8'h20,
        8'h46, 8'h75, 8'h6C, 8'h6C,
        8'h2A, 8'h2A, 8'h2A,
        8'h0A, 8'h0D, 8'h0A, 8'h0D
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CR,
        ST_NOTICE,
        ST_POP,
        ST_FINISH
    } txrq_state_t;

endpackage

// ===== design/tx_ring_queue_crlf_unit.sv =====
// Transmit ring queue for a serial port. Each input transaction either enqueues
// s_data_byte (s_func = 0) or pops the oldest byte for the transmitter (s_func = 1),
// and every input transaction yields exactly one result transaction carrying the
// status, the popped byte (m_tx_valid/m_tx_byte, zero when nothing popped) and the
// fill level afterwards. A line feed is followed in the queue by a carriage return.
// An enqueue that finds the queue full clears it, loads a 25-byte overflow notice
// and reports status 1 (status stays 0 if the full condition hits the appended
// carriage return). A plain enqueue or a pop of an empty queue loads the result in
// the cycle it is accepted; an enqueued line feed passes ST_CR, where the carriage
// return goes in on the following cycle (the store has a single write port), then
// ST_FINISH; a pop passes ST_POP, as the store read data is registered; an overflow
// writes one notice byte per cycle via the write port in ST_NOTICE, then reports
// in ST_FINISH. The input is not ready while an item is in work, or while the
// result register is still held by the far side.
module tx_ring_queue_crlf_unit
    import txrq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_func,
    input  logic [7:0]        s_data_byte,

    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_status,
    output logic              m_tx_valid,
    output logic [7:0]        m_tx_byte,
    output logic [FILL_W-1:0] m_fill_level
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    // Byte store: one write port, one registered read port
    logic [7:0] mem [QUEUE_DEPTH];
    logic [7:0] rd_data_reg;

    txrq_state_t state_reg, state_next;

    logic [PTR_W-1:0]        rp_reg, rp_next;
    logic [PTR_W-1:0]        wp_reg, wp_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [NOTICE_IDX_W-1:0] idx_reg, idx_next;
    logic                    res_status_reg, res_status_next;

    // Result register
    logic              m_valid_reg;
    logic              m_status_reg;
    logic              m_tx_valid_reg;
    logic [7:0]        m_tx_byte_reg;
    logic [FILL_W-1:0] m_fill_level_reg;

    logic              accept;
    logic              out_free;
    logic              full;
    logic [PTR_W-1:0]  wp_inc;
    logic [PTR_W-1:0]  rp_inc;

    logic              mem_we;
    logic [7:0]        mem_wdata;
    logic              mem_re;

    logic              out_load;
    logic              out_status;
    logic              out_tx_valid;
    logic [7:0]        out_tx_byte;
    logic [CNT_W-1:0]  out_fill;

    // Result register is free if empty or being taken this cycle
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign full     = (count_reg >= DEPTH_CNT);

    // Pointer wrap (depth need not be a power of two)
    assign wp_inc = (wp_reg == PTR_LAST) ? '0 : wp_reg + PTR_W'(1);
    assign rp_inc = (rp_reg == PTR_LAST) ? '0 : rp_reg + PTR_W'(1);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!s_func) begin
                        if (full) begin
                            state_next = ST_NOTICE;
                        end else if (s_data_byte == CHAR_LF) begin
                            state_next = ST_CR;
                        end
                    end else if (count_reg != '0) begin
                        state_next = ST_POP;
                    end
                end
            end
            ST_CR: begin
                state_next = full ? ST_NOTICE : ST_FINISH;
            end
            ST_NOTICE: begin
                if (idx_reg == NOTICE_LAST) begin
                    state_next = ST_FINISH;
                end
            end
            ST_POP, ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath control
    always_comb begin
        rp_next         = rp_reg;
        wp_next         = wp_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        mem_we          = 1'b0;
        mem_wdata       = s_data_byte;
        mem_re          = 1'b0;
        out_load        = 1'b0;
        out_status      = 1'b0;
        out_tx_valid    = 1'b0;
        out_tx_byte     = '0;
        out_fill        = count_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!s_func) begin
                        if (full) begin
                            // overflow: clear, then load the notice
                            rp_next         = '0;
                            wp_next         = '0;
                            count_next      = '0;
                            idx_next        = '0;
                            res_status_next = 1'b1;
                        end else begin
                            mem_we     = 1'b1;
                            wp_next    = wp_inc;
                            count_next = count_reg + CNT_W'(1);
                            if (s_data_byte != CHAR_LF) begin
                                out_load = 1'b1;
                                out_fill = count_reg + CNT_W'(1);
                            end
                        end
                    end else if (count_reg != '0) begin
                        mem_re     = 1'b1;
                        rp_next    = rp_inc;
                        count_next = count_reg - CNT_W'(1);
                    end else begin
                        out_load = 1'b1;
                    end
                end
            end
            ST_CR: begin
                res_status_next = 1'b0;
                if (full) begin
                    // filled up by the line feed itself
                    rp_next    = '0;
                    wp_next    = '0;
                    count_next = '0;
                    idx_next   = '0;
                end else begin
                    mem_we     = 1'b1;
                    mem_wdata  = CHAR_CR;
                    wp_next    = wp_inc;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ST_NOTICE: begin
                mem_we     = 1'b1;
                mem_wdata  = NOTICE_ROM[idx_reg];
                wp_next    = wp_inc;
                count_next = count_reg + CNT_W'(1);
                idx_next   = idx_reg + NOTICE_IDX_W'(1);
            end
            ST_POP: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    out_tx_valid = 1'b1;
                    out_tx_byte  = rd_data_reg;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_status = res_status_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rp_reg      <= '0;
            wp_reg      <= '0;
            count_reg   <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            rp_reg    <= rp_next;
            wp_reg    <= wp_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        if (out_load) begin
            m_status_reg     <= out_status;
            m_tx_valid_reg   <= out_tx_valid;
            m_tx_byte_reg    <= out_tx_byte;
            m_fill_level_reg <= FILL_W'(out_fill);
        end
    end

    // Store write and registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wp_reg] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_data_reg <= mem[rp_reg];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_tx_valid   = m_tx_valid_reg;
    assign m_tx_byte    = m_tx_byte_reg;
    assign m_fill_level = m_fill_level_reg;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_CNT)
        else $error("byte count above queue depth");

    a_notice_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_NOTICE) |-> (count_reg == CNT_W'(idx_reg)))
        else $error("notice load out of step with byte count");

    a_pop_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_func && (count_reg != '0)) |=> (state_reg == ST_POP))
        else $error("pop of a non-empty queue did not start a read");

    a_pop_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_tx_valid) |-> !m_status)
        else $error("popped byte reported with error status");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result register overwritten before it was taken");

endmodule
